// ===== hw/rtl/cpu8_pkg.sv =====
package cpu8_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int QDEPTH    = 2;

    typedef enum logic [1:0] {
        OP_EXEC = 2'd0,
        OP_POKE = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY
    } mode_t;

    typedef enum logic [4:0] {
        K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
        K_ASL, K_ROL, K_LSR, K_ROR, K_STX, K_LDX, K_DEC, K_INC,
        K_BIT, K_STY, K_LDY, K_CPY, K_CPX,
        K_INX, K_INY, K_DEX, K_DEY, K_TAX, K_TAY, K_TXA, K_TYA,
        K_POKE, K_PEEK, K_BAD
    } kind_t;

    // one classified item as it sits in the queue
    typedef struct packed {
        kind_t       kind;
        mode_t       mode;
        logic [15:0] operand;
        logic [7:0]  poke_data;
    } cmd_t;

    function automatic mode_t group_one_mode(input logic [2:0] bbb);
        mode_t m;
        m = AM_IMP;
        unique case (bbb)
            3'd0: m = AM_INDX;
            3'd1: m = AM_ZP;
            3'd2: m = AM_IMM;
            3'd3: m = AM_ABS;
            3'd4: m = AM_INDY;
            3'd5: m = AM_ZPX;
            3'd6: m = AM_ABSY;
            3'd7: m = AM_ABSX;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/cpu8_ram.sv =====
module cpu8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/cpu8_decode.sv =====
module cpu8_decode
    import cpu8_pkg::*;
(
    input  logic [1:0]  op,
    input  logic [7:0]  opcode,
    input  logic [15:0] operand,
    input  logic [7:0]  poke_data,
    output cmd_t        cmd
);

    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    kind_t      kind;
    mode_t      mode;
    logic       ok;

    assign aaa = opcode[7:5];
    assign bbb = opcode[4:2];
    assign cc  = opcode[1:0];

    always_comb
    begin
        kind = K_BAD;
        mode = AM_IMP;
        ok   = 1'b0;
        unique case (opcode)
            8'h0A: begin kind = K_ASL; ok = 1'b1; end
            8'h2A: begin kind = K_ROL; ok = 1'b1; end
            8'h4A: begin kind = K_LSR; ok = 1'b1; end
            8'h6A: begin kind = K_ROR; ok = 1'b1; end
            8'hE8: begin kind = K_INX; ok = 1'b1; end
            8'hC8: begin kind = K_INY; ok = 1'b1; end
            8'hCA: begin kind = K_DEX; ok = 1'b1; end
            8'h88: begin kind = K_DEY; ok = 1'b1; end
            8'hAA: begin kind = K_TAX; ok = 1'b1; end
            8'hA8: begin kind = K_TAY; ok = 1'b1; end
            8'h8A: begin kind = K_TXA; ok = 1'b1; end
            8'h98: begin kind = K_TYA; ok = 1'b1; end
            default:
            begin
                if (cc == 2'd1)
                begin
                    kind = kind_t'({2'b00, aaa});
                    mode = group_one_mode(bbb);
                    ok   = (opcode != 8'h89);
                end
                else if (cc == 2'd2)
                begin
                    kind = kind_t'(5'd8 + {2'b00, aaa});
                    unique case (bbb)
                        3'd0: begin mode = AM_IMM; ok = (aaa == 3'd5); end
                        3'd1: begin mode = AM_ZP; ok = 1'b1; end
                        3'd3: begin mode = AM_ABS; ok = 1'b1; end
                        3'd5:
                        begin
                            mode = (aaa == 3'd4 || aaa == 3'd5) ? AM_ZPY : AM_ZPX;
                            ok   = 1'b1;
                        end
                        3'd7:
                        begin
                            mode = (aaa == 3'd5) ? AM_ABSY : AM_ABSX;
                            ok   = (aaa != 3'd4);
                        end
                        default: ok = 1'b0;
                    endcase
                end
                else if (cc == 2'd0 && aaa != 3'd0 && aaa != 3'd2 && aaa != 3'd3)
                begin
                    kind = (aaa == 3'd1) ? K_BIT : kind_t'(5'd13 + {2'b00, aaa});
                    unique case (bbb)
                        3'd0: begin mode = AM_IMM; ok = (aaa >= 3'd5); end
                        3'd1: begin mode = AM_ZP; ok = 1'b1; end
                        3'd3: begin mode = AM_ABS; ok = 1'b1; end
                        3'd5: begin mode = AM_ZPX; ok = (aaa == 3'd4 || aaa == 3'd5); end
                        3'd7: begin mode = AM_ABSX; ok = (aaa == 3'd5); end
                        default: ok = 1'b0;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        cmd.operand   = operand;
        cmd.poke_data = poke_data;
        cmd.mode      = AM_IMP;
        unique case (op_t'(op))
            OP_EXEC:
            begin
                cmd.kind = ok ? kind : K_BAD;
                cmd.mode = ok ? mode : AM_IMP;
            end
            OP_POKE: cmd.kind = K_POKE;
            OP_PEEK: cmd.kind = K_PEEK;
            default: cmd.kind = K_BAD;
        endcase
    end

endmodule

// ===== hw/rtl/cpu8_queue.sv =====
module cpu8_queue
    import cpu8_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PW = $clog2(QDEPTH);

    cmd_t          slot_reg [QDEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== hw/rtl/cpu8_exec.sv =====
module cpu8_exec
    import cpu8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [47:0] res_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PTRLO = 7'b0000010,
        S_PTRHI = 7'b0000100,
        S_READ  = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_EXEC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        c_reg, c_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next, p_reg, p_next;
    logic [7:0]  rd_reg, rd_next;
    logic        bad_reg, bad_next;
    logic [7:0]  plo_reg, plo_next;
    logic [15:0] ea_reg, ea_next;
    logic        ov_reg, ov_next;

    logic              we;
    logic [MEM_AW-1:0] maddr;
    logic [15:0]       maddr16;
    logic [7:0]        wdata, mdata, m;
    logic [8:0]        sum;
    logic [7:0]        r8;
    logic              cin;
    logic              mem_mode, is_store;

    cpu8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (maddr),
        .wdata (wdata),
        .rdata (mdata)
    );

    assign maddr    = maddr16[MEM_AW-1:0];
    assign res_valid = ov_reg;
    assign res_data  = {7'd0, bad_reg, rd_reg, p_reg, y_reg, x_reg, a_reg};
    assign cin       = p_reg[0];
    assign mem_mode  = (c_reg.mode != AM_IMP) && (c_reg.mode != AM_IMM);
    assign is_store  = (c_reg.kind == K_STA) || (c_reg.kind == K_STX) || (c_reg.kind == K_STY);
    assign m = (c_reg.mode == AM_IMM) ? c_reg.operand[7:0] : mdata;

    always_comb
    begin
        state_next = state_reg;
        c_next = c_reg;
        a_next = a_reg; x_next = x_reg; y_next = y_reg; p_next = p_reg;
        rd_next = rd_reg; bad_next = bad_reg; plo_next = plo_reg; ea_next = ea_reg;
        ov_next = ov_reg;
        we = 1'b0; maddr16 = ea_reg; wdata = 8'd0;
        cmd_pop = 1'b0;
        sum = 9'd0; r8 = 8'd0;
        if (ov_reg && res_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    c_next = cmd;
                    unique case (cmd.mode)
                        AM_ZP:   ea_next = {8'd0, cmd.operand[7:0]};
                        AM_ZPX:  ea_next = {8'd0, cmd.operand[7:0] + x_reg};
                        AM_ZPY:  ea_next = {8'd0, cmd.operand[7:0] + y_reg};
                        AM_ABSX: ea_next = cmd.operand + {8'd0, x_reg};
                        AM_ABSY: ea_next = cmd.operand + {8'd0, y_reg};
                        AM_INDX: ea_next = {8'd0, cmd.operand[7:0] + x_reg};
                        AM_INDY: ea_next = {8'd0, cmd.operand[7:0]};
                        default: ea_next = cmd.operand;
                    endcase
                    if (cmd.mode == AM_INDX || cmd.mode == AM_INDY)
                        state_next = S_PTRLO;
                    else if (cmd.kind == K_POKE)
                        state_next = S_EXEC;
                    else if (cmd.kind == K_PEEK)
                        state_next = S_READ;
                    else if (cmd.mode == AM_IMP || cmd.mode == AM_IMM)
                        state_next = S_EXEC;
                    else
                        state_next = S_READ;
                end
            end
            S_PTRLO:
            begin
                // pointer low byte read issued, then the high byte
                maddr16 = ea_reg;
                ea_next = {8'd0, ea_reg[7:0] + 8'd1};
                state_next = S_PTRHI;
            end
            S_PTRHI:
            begin
                maddr16 = ea_reg;
                plo_next = mdata;
                state_next = S_READ;
                ea_next = 16'd0;
            end
            S_READ:
            begin
                if (c_reg.mode == AM_INDX || c_reg.mode == AM_INDY)
                begin
                    ea_next = {mdata, plo_reg} +
                              ((c_reg.mode == AM_INDY) ? {8'd0, y_reg} : 16'd0);
                    maddr16 = ea_next;
                end
                state_next = (is_store) ? S_EXEC : S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!ov_reg || res_ready)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                    rd_next = 8'd0;
                    bad_next = 1'b0;
                    unique case (c_reg.kind)
                        K_POKE: begin we = 1'b1; wdata = c_reg.poke_data; end
                        K_PEEK: rd_next = mdata;
                        K_BAD:  bad_next = 1'b1;
                        K_ORA: a_next = a_reg | m;
                        K_AND: a_next = a_reg & m;
                        K_EOR: a_next = a_reg ^ m;
                        K_ADC:
                        begin
                            sum = {1'b0, a_reg} + {1'b0, m} + {8'd0, cin};
                            a_next = sum[7:0];
                            p_next[0] = sum[8];
                            p_next[6] = (~(a_reg[7] ^ m[7])) & (a_reg[7] ^ sum[7]);
                        end
                        K_SBC:
                        begin
                            sum = {1'b0, a_reg} - {1'b0, m} - {8'd0, ~cin};
                            a_next = sum[7:0];
                            p_next[0] = ~sum[8];
                            p_next[6] = (a_reg[7] ^ m[7]) & (a_reg[7] ^ sum[7]);
                        end
                        K_STA: begin we = 1'b1; wdata = a_reg; end
                        K_STX: begin we = 1'b1; wdata = x_reg; end
                        K_STY: begin we = 1'b1; wdata = y_reg; end
                        K_LDA: a_next = m;
                        K_LDX: x_next = m;
                        K_LDY: y_next = m;
                        K_CMP, K_CPX, K_CPY:
                        begin
                            r8 = (c_reg.kind == K_CMP) ? a_reg :
                                 (c_reg.kind == K_CPX) ? x_reg : y_reg;
                            sum = {1'b0, r8} - {1'b0, m};
                            p_next[0] = ~sum[8];
                        end
                        K_BIT:
                        begin
                            p_next[1] = ((a_reg & m) == 8'd0);
                            p_next[6] = m[6];
                            p_next[7] = m[7];
                        end
                        K_ASL, K_ROL, K_LSR, K_ROR:
                        begin
                            r8 = mem_mode ? m : a_reg;
                            unique case (c_reg.kind)
                                K_ASL: begin p_next[0] = r8[7]; r8 = {r8[6:0], 1'b0}; end
                                K_ROL: begin p_next[0] = r8[7]; r8 = {r8[6:0], cin}; end
                                K_LSR: begin p_next[0] = r8[0]; r8 = {1'b0, r8[7:1]}; end
                                default: begin p_next[0] = r8[0]; r8 = {cin, r8[7:1]}; end
                            endcase
                            if (mem_mode) begin we = 1'b1; wdata = r8; end
                            else a_next = r8;
                        end
                        K_INC: begin r8 = m + 8'd1; we = 1'b1; wdata = r8; end
                        K_DEC: begin r8 = m - 8'd1; we = 1'b1; wdata = r8; end
                        K_INX: begin r8 = x_reg + 8'd1; x_next = r8; end
                        K_INY: begin r8 = y_reg + 8'd1; y_next = r8; end
                        K_DEX: begin r8 = x_reg - 8'd1; x_next = r8; end
                        K_DEY: begin r8 = y_reg - 8'd1; y_next = r8; end
                        K_TAX: x_next = a_reg;
                        K_TAY: y_next = a_reg;
                        K_TXA: a_next = x_reg;
                        default: a_next = y_reg;
                    endcase
                    // n and z from the value the instruction produced
                    unique case (c_reg.kind)
                        K_ORA, K_AND, K_EOR, K_ADC, K_SBC, K_LDA, K_TXA, K_TYA:
                            begin p_next[1] = (a_next == 8'd0); p_next[7] = a_next[7]; end
                        K_LDX, K_TAX:
                            begin p_next[1] = (x_next == 8'd0); p_next[7] = x_next[7]; end
                        K_LDY, K_TAY:
                            begin p_next[1] = (y_next == 8'd0); p_next[7] = y_next[7]; end
                        K_CMP, K_CPX, K_CPY, K_ASL, K_ROL, K_LSR, K_ROR,
                        K_INC, K_DEC, K_INX, K_INY, K_DEX, K_DEY:
                            begin p_next[1] = (sum[7:0] == 8'd0) && (r8 == 8'd0 ||
                                  c_reg.kind == K_CMP || c_reg.kind == K_CPX ||
                                  c_reg.kind == K_CPY);
                                  p_next[7] = (c_reg.kind == K_CMP || c_reg.kind == K_CPX ||
                                  c_reg.kind == K_CPY) ? sum[7] : r8[7];
                                  if (!(c_reg.kind == K_CMP || c_reg.kind == K_CPX ||
                                        c_reg.kind == K_CPY))
                                      p_next[1] = (r8 == 8'd0);
                            end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg <= 8'd0; x_reg <= 8'd0; y_reg <= 8'd0; p_reg <= 8'd0;
            rd_reg <= 8'd0; bad_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg <= a_next; x_reg <= x_next; y_reg <= y_next; p_reg <= p_next;
            rd_reg <= rd_next; bad_reg <= bad_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        plo_reg <= plo_next;
        ea_reg  <= ea_next;
    end

endmodule

// ===== hw/rtl/cpu8_instruction_executor_top.sv =====
// an item is queued, then the back end walks its states: idle, pointer reads (indirect modes),
// operand read and wait (memory modes), exec; the result is registered and held until taken
// the back end, with its single-port byte memory, takes a new item only once it is through with the last
// the front end decodes and queues up to two items while the back end works or stalls
// reset: asynchronous active-low rst_n clears a, x, y, status and the queue;
// memory contents are undefined until written
module cpu8_instruction_executor_top
    import cpu8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], opcode[9:2], operand[25:10], poke_data[33:26], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // acc_out[7:0], x_out[15:8], y_out[23:16], status_out[31:24], read_data[39:32],
    // unsupported[40], zero fill
    output logic [47:0] m_axis_tdata
);

    cmd_t dec_cmd;
    cmd_t q_head;
    logic q_full, q_empty, q_pop;

    // front end: classify the opcode into operation kind and addressing mode
    cpu8_decode u_decode (
        .op        (s_axis_tdata[1:0]),
        .opcode    (s_axis_tdata[9:2]),
        .operand   (s_axis_tdata[25:10]),
        .poke_data (s_axis_tdata[33:26]),
        .cmd       (dec_cmd)
    );

    assign s_axis_tready = !q_full;

    // decoded items wait here so input and execution stall independently
    cpu8_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && !q_full),
        .push_data (dec_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // back end: address generation, memory access and alu
    cpu8_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata)
    );

endmodule
